### design/pxu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pxu_pkg;

	localparam int ADDRESS_WIDTH_DEFAULT = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_ADDR_W = 32;

	localparam logic [7:0] INDEX_MASKED = 8'hFF;
	localparam logic [7:0] INDEX_ONE_SET = 8'd3;
	localparam logic [7:0] INDEX_ONE_CLEAR = 8'd0;
	localparam logic [7:0] MASKED_COLOR_RESET = 8'hFF;

	typedef enum logic [1:0] {
		MODE_1BPP,
		MODE_2BPP,
		MODE_4BPP,
		MODE_8BPP
	} mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PIXEL_MODE  = 3'd0,
		CFG_FRAME_WIDTH = 3'd1,
		CFG_FRAME_HEIGHT = 3'd2,
		CFG_ORIGIN_X    = 3'd3,
		CFG_ORIGIN_Y    = 3'd4,
		CFG_ROW_PITCH   = 3'd5,
		CFG_MASK_ENABLE = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		mode_t       pixel_mode;
		logic [15:0] frame_width;
		logic [15:0] frame_height;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [15:0] row_pitch;
		logic        mask_enable;
	} cfg_t;

	typedef struct packed {
		logic       frame_start;
		logic [7:0] data_byte;
		logic [7:0] mask_byte;
	} in_item_t;

	typedef struct packed {
		logic [OUT_ADDR_W-1:0] pixel_address;
		logic [7:0]            pixel_index;
		logic [7:0]            masked_color;
		logic                  frame_done;
		logic                  last;
	} out_item_t;

	typedef struct packed {
		logic       frame_start;
		logic [7:0] data_byte;
		logic [3:0] mask_bits;
	} job_t;

	typedef struct packed {
		logic                             full;
		logic                             empty;
		logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
	} q_stat_t;

endpackage
`default_nettype wire

### design/pxu_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pxu_byte_if;
	logic               valid;
	logic               ready;
	pxu_pkg::in_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface pxu_pixel_if;
	logic                valid;
	logic                ready;
	pxu_pkg::out_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

### design/pxu_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pxu_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	pxu_byte_if.sink              byte_ch,
	input  wire pxu_pkg::mode_t   pixel_mode,
	input  wire logic             mask_enable,
	input  wire logic             q_full,
	output logic                  push,
	output pxu_pkg::job_t         job
);

	logic [1:0] phase_q;
	logic [1:0] phase;
	logic [7:0] mbyte;

	assign byte_ch.ready = !q_full;
	assign push = byte_ch.valid && !q_full;
	assign phase = byte_ch.payload.frame_start ? 2'd0 : phase_q;
	assign mbyte = byte_ch.payload.mask_byte;

	always_comb begin
		job.frame_start = byte_ch.payload.frame_start;
		job.data_byte = byte_ch.payload.data_byte;
		job.mask_bits = 4'd0;
		if (mask_enable) begin
			case (pixel_mode)
				pxu_pkg::MODE_2BPP: begin
					job.mask_bits = phase[0] ? mbyte[3:0] : mbyte[7:4];
				end
				pxu_pkg::MODE_4BPP: begin
					case (phase)
						2'd0: job.mask_bits = {2'b00, mbyte[7:6]};
						2'd1: job.mask_bits = {2'b00, mbyte[5:4]};
						2'd2: job.mask_bits = {2'b00, mbyte[3:2]};
						default: job.mask_bits = {2'b00, mbyte[1:0]};
					endcase
				end
				default: job.mask_bits = 4'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
		end else if (push) begin
			phase_q <= phase + 2'd1;
		end
	end

endmodule
`default_nettype wire

### design/pxu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module pxu_queue #(
	parameter int DEPTH = pxu_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire pxu_pkg::job_t   wr_job,
	input  wire logic            pop,
	output pxu_pkg::job_t        rd_job,
	output pxu_pkg::q_stat_t     stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pxu_pkg::job_t    entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign rd_job = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### design/pxu_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pxu_back #(
	parameter int ADDRESS_WIDTH = pxu_pkg::ADDRESS_WIDTH_DEFAULT
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pxu_pkg::cfg_t   cfg,
	input  wire pxu_pkg::job_t   job,
	input  wire logic            q_empty,
	output logic                 pop,
	pxu_pixel_if.source          pixel_ch
);

	logic [15:0]         column_q;
	logic [15:0]         row_q;
	logic                finished_q;
	logic [7:0]          lmc_q;
	logic [2:0]          pix_q;
	logic                out_valid_q;
	pxu_pkg::out_item_t out_item_q;

	logic        load_ok;
	logic        start;
	logic [15:0] col_e;
	logic [15:0] row_e;
	logic        fin_e;
	logic [3:0]  count;
	logic [3:0]  shift;
	logic [7:0]  bpp_mask;
	logic [7:0]  color;
	logic [3:0]  mpos;
	logic        hit;
	logic [7:0]  index;
	logic [7:0]  lmc_next;
	logic        col_wrap;
	logic        row_wrap;
	logic        done;
	logic        end_px;
	logic        emit;
	logic [16:0] y_sum;
	logic [16:0] x_sum;
	logic [32:0] prod;
	logic [63:0] addr_full;
	logic [63:0] addr_mask;
	logic [63:0] addr_wrapped;

	assign load_ok = !out_valid_q || pixel_ch.ready;
	assign start = job.frame_start && (pix_q == 3'd0);
	assign col_e = start ? 16'd0 : column_q;
	assign row_e = start ? 16'd0 : row_q;
	assign fin_e = start ? 1'b0 : finished_q;

	always_comb begin
		case (cfg.pixel_mode)
			pxu_pkg::MODE_1BPP: begin
				count = 4'd8;
				bpp_mask = 8'h01;
			end
			pxu_pkg::MODE_2BPP: begin
				count = 4'd4;
				bpp_mask = 8'h03;
			end
			pxu_pkg::MODE_4BPP: begin
				count = 4'd2;
				bpp_mask = 8'h0F;
			end
			default: begin
				count = 4'd1;
				bpp_mask = 8'hFF;
			end
		endcase
	end

	assign shift = 4'd8 - (({1'b0, pix_q} + 4'd1) << cfg.pixel_mode);
	assign color = (job.data_byte >> shift) & bpp_mask;
	assign mpos = count - 4'd1 - {1'b0, pix_q};
	assign hit = job.mask_bits[mpos[1:0]];

	always_comb begin
		lmc_next = lmc_q;
		if (cfg.pixel_mode == pxu_pkg::MODE_1BPP) begin
			index = (color != 8'd0) ? pxu_pkg::INDEX_ONE_SET : pxu_pkg::INDEX_ONE_CLEAR;
		end else if (hit) begin
			index = pxu_pkg::INDEX_MASKED;
			lmc_next = color;
		end else begin
			index = color;
		end
	end

	assign col_wrap = ({1'b0, col_e} + 17'd1) >= {1'b0, cfg.frame_width};
	assign row_wrap = ({1'b0, row_e} + 17'd1) >= {1'b0, cfg.frame_height};
	assign done = col_wrap && row_wrap;
	assign end_px = done || (({1'b0, pix_q} + 4'd1) == count);

	assign y_sum = {1'b0, row_e} + {1'b0, cfg.origin_y};
	assign x_sum = {1'b0, col_e} + {1'b0, cfg.origin_x};
	assign prod = y_sum * cfg.row_pitch;
	assign addr_full = 64'(prod) + 64'(x_sum);
	assign addr_mask = {64{1'b1}} >> (64 - ADDRESS_WIDTH);
	assign addr_wrapped = addr_full & addr_mask;

	assign emit = !q_empty && load_ok && !fin_e;
	assign pop = !q_empty && load_ok && (fin_e || end_px);

	assign pixel_ch.valid = out_valid_q;
	assign pixel_ch.payload = out_item_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_item_q.pixel_address <= addr_wrapped[pxu_pkg::OUT_ADDR_W-1:0];
			out_item_q.pixel_index <= index;
			out_item_q.masked_color <= lmc_next;
			out_item_q.frame_done <= done;
			out_item_q.last <= end_px;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= 16'd0;
			row_q <= 16'd0;
			finished_q <= 1'b0;
			lmc_q <= pxu_pkg::MASKED_COLOR_RESET;
			pix_q <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_ok) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				column_q <= col_wrap ? 16'd0 : col_e + 16'd1;
				row_q <= (col_wrap && !row_wrap) ? row_e + 16'd1 : row_e;
				finished_q <= done;
				lmc_q <= lmc_next;
				pix_q <= end_px ? 3'd0 : pix_q + 3'd1;
			end
		end
	end

endmodule
`default_nettype wire

### design/packed_pixel_unpacker_with_mask_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Unpacks bytes of 1, 2, 4 or 8 bits per pixel into one 8-bit palette index per
// pixel with its destination address (row + origin_y) * row_pitch + column + origin_x.
// The front stage takes one byte per cycle into a four-entry queue whenever the queue
// has room; the pixel emitter behind it produces one pixel per cycle unless the output
// stalls, so a byte yields 8, 4, 2 or 1 pixels at 1, 2, 4 or 8 bits per pixel (fewer if
// the frame ends in it, none once the frame is done), each offered from a register after
// the queue. Users must write registers only while the block is idle; it is not enforced.
module packed_pixel_unpacker_with_mask_core #(
	parameter int ADDRESS_WIDTH = pxu_pkg::ADDRESS_WIDTH_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [pxu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [pxu_pkg::CFG_DATA_W-1:0]  cfg_data,
	pxu_byte_if.sink                             byte_ch,
	pxu_pixel_if.source                          pixel_ch
);

	pxu_pkg::cfg_t    cfg_q;
	pxu_pkg::job_t    wr_job;
	pxu_pkg::job_t    rd_job;
	pxu_pkg::q_stat_t q_stat;
	logic             push;
	logic             pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_mode <= pxu_pkg::MODE_1BPP;
			cfg_q.frame_width <= 16'd8;
			cfg_q.frame_height <= 16'd8;
			cfg_q.origin_x <= 16'd0;
			cfg_q.origin_y <= 16'd0;
			cfg_q.row_pitch <= 16'd1024;
			cfg_q.mask_enable <= 1'b0;
		end else if (cfg_write) begin
			case (pxu_pkg::cfg_idx_t'(cfg_index))
				pxu_pkg::CFG_PIXEL_MODE: cfg_q.pixel_mode <= pxu_pkg::mode_t'(cfg_data[1:0]);
				pxu_pkg::CFG_FRAME_WIDTH: cfg_q.frame_width <= cfg_data;
				pxu_pkg::CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				pxu_pkg::CFG_ORIGIN_X: cfg_q.origin_x <= cfg_data;
				pxu_pkg::CFG_ORIGIN_Y: cfg_q.origin_y <= cfg_data;
				pxu_pkg::CFG_ROW_PITCH: cfg_q.row_pitch <= cfg_data;
				pxu_pkg::CFG_MASK_ENABLE: cfg_q.mask_enable <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	pxu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_ch     (byte_ch),
		.pixel_mode  (cfg_q.pixel_mode),
		.mask_enable (cfg_q.mask_enable),
		.q_full      (q_stat.full),
		.push        (push),
		.job         (wr_job)
	);

	pxu_queue #(
		.DEPTH (pxu_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.stat   (q_stat)
	);

	pxu_back #(
		.ADDRESS_WIDTH (ADDRESS_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.job      (rd_job),
		.q_empty  (q_stat.empty),
		.pop      (pop),
		.pixel_ch (pixel_ch)
	);

`ifndef NO_ASSERTIONS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty))
		else $error("queue popped while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= pxu_pkg::QUEUE_DEPTH)
		else $error("queue count beyond depth");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_ch.valid && pixel_ch.payload.frame_done |-> pixel_ch.payload.last)
		else $error("frame end beat without last");

	a_masked_color_range: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_ch.valid && (cfg_q.pixel_mode == pxu_pkg::MODE_2BPP
			|| cfg_q.pixel_mode == pxu_pkg::MODE_4BPP)
			&& pixel_ch.payload.pixel_index == pxu_pkg::INDEX_MASKED
		|-> pixel_ch.payload.masked_color <= 8'd15)
		else $error("masked beat carries an out of range color");
`endif

endmodule
`default_nettype wire
